[hdl/bsc_pkg.sv]
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

    localparam int DIV_BITS_PER_STAGE = 2;

    // Divider operand widths, fixed by the field ranges
    localparam int T_NUM_W = 27;
    localparam int T_DEN_W = 19;
    localparam int P_NUM_W = 32;
    localparam int P_DEN_W = 17;

    localparam int C_B6_OFFSET = 4000;
    localparam int C_B7_SCALE  = 50000;
    localparam int C_K_SQ      = 3038;
    localparam int C_K_LIN     = 7357;
    localparam int C_K_OFS     = 3791;
    localparam int C_RECIP10   = 52429;   // ceil(2^19 / 10)
    localparam int C_PRES_MAX  = 262143;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC123 = 2'd0,
        REG_AC456 = 2'd1,
        REG_B12   = 2'd2,
        REG_MCMD  = 2'd3
    } bsc_reg_t;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } bsc_cal_t;

    // Carried alongside the temperature divider
    typedef struct packed {
        logic signed [17:0] x1;
        logic [18:0]        up;
        logic [1:0]         oss;
        logic               qneg;
        logic               dz;
    } bsc_tside_t;

    // Carried alongside the pressure divider
    typedef struct packed {
        logic signed [15:0] tenths;
        logic               big;
        logic               err;
    } bsc_pside_t;

    typedef struct packed {
        logic               err;
        logic [17:0]        pressure;
        logic signed [12:0] degrees;
        logic signed [15:0] tenths;
    } bsc_res_t;

endpackage

[hdl/bsc_div.sv]
// Pipelined unsigned restoring divider with a sideband that travels along.
module bsc_div #(
    parameter int DW  = 32,
    parameter int VW  = 17,
    parameter int SW  = 1,
    parameter int SPS = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_num,
    input  logic [VW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_quo,
    output logic [SW-1:0] out_side
);
    localparam int NSTG = (DW + SPS - 1) / SPS;
    localparam int AW   = VW + DW;

    // acc holds {remainder, dividend bits not yet used / quotient bits}
    logic [AW-1:0] acc_reg  [NSTG];
    logic [AW-1:0] acc_next [NSTG];
    logic [AW-1:0] acc_in   [NSTG];
    logic [VW-1:0] den_reg  [NSTG];
    logic [VW-1:0] den_in   [NSTG];
    logic [SW-1:0] side_reg [NSTG];
    logic [NSTG-1:0] vld_reg;

    always_comb begin
        acc_in[0] = {{VW{1'b0}}, in_num};
        den_in[0] = in_den;
        for (int s = 1; s < NSTG; s++) begin
            acc_in[s] = acc_reg[s-1];
            den_in[s] = den_reg[s-1];
        end
    end

    always_comb begin
        logic [AW-1:0] acc_w;
        logic [VW:0]   top;
        for (int s = 0; s < NSTG; s++) begin
            acc_w = acc_in[s];
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < DW) begin
                    top = acc_w[AW-1:DW-1];
                    if (top >= {1'b0, den_in[s]}) begin
                        top   = top - {1'b0, den_in[s]};
                        acc_w = {top[VW-1:0], acc_w[DW-2:0], 1'b1};
                    end else begin
                        acc_w = {top[VW-1:0], acc_w[DW-2:0], 1'b0};
                    end
                end
            end
            acc_next[s] = acc_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NSTG; s++) begin
                acc_reg[s] <= acc_next[s];
                den_reg[s] <= den_in[s];
            end
            side_reg[0] <= in_side;
            for (int s = 1; s < NSTG; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_quo   = acc_reg[NSTG-1][DW-1:0];
    assign out_side  = side_reg[NSTG-1];

endmodule

[hdl/bsc_coef.sv]
// Five-stage pipeline from the temperature quotient to the pressure divider operands.
module bsc_coef (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  bsc_pkg::bsc_cal_t        cal,
    input  logic                     in_valid,
    input  logic [bsc_pkg::T_NUM_W-1:0] in_quo,
    input  bsc_pkg::bsc_tside_t      in_side,
    output logic                     out_valid,
    output logic [bsc_pkg::P_NUM_W-1:0] out_num,
    output logic [bsc_pkg::P_DEN_W-1:0] out_den,
    output bsc_pkg::bsc_pside_t      out_side
);
    import bsc_pkg::*;

    logic [4:0] vld_reg;

    // stage A: B5, B6
    logic signed [27:0] x2_a;
    logic signed [28:0] b5_a_next, b6_a_next;
    logic signed [28:0] b5_a_reg, b6_a_reg;
    logic [18:0]        up_a_reg;
    logic [1:0]         oss_a_reg;
    logic               dz_a_reg;

    // stage B: B6 squared and linear terms, temperature
    logic signed [57:0] sq_b;
    logic signed [44:0] p_ac2, p_ac3;
    logic signed [24:0] tt_b;
    logic signed [15:0] tenths_b_next;
    logic [42:0]        b6sq_b_reg;
    logic signed [33:0] x2b_b_reg;
    logic signed [31:0] x1c_b_reg;
    logic signed [15:0] tenths_b_reg;
    logic [18:0]        up_b_reg;
    logic [1:0]         oss_b_reg;
    logic               dz_b_reg;

    // stage C: B2 and B1 products
    logic signed [59:0] p_b2, p_b1;
    logic signed [48:0] x1b_c_reg;
    logic signed [33:0] x2b_c_reg;
    logic signed [31:0] x1c_c_reg;
    logic signed [43:0] x2c_c_reg;
    logic signed [15:0] tenths_c_reg;
    logic [18:0]        up_c_reg;
    logic [1:0]         oss_c_reg;
    logic               dz_c_reg;

    // stage D: B3 and the B4 multiplicand
    logic signed [49:0] x3_d;
    logic signed [54:0] v_d, b3_d;
    logic signed [44:0] x3c_d;
    logic [31:0]        b3lo_d_reg, t_d_reg;
    logic signed [15:0] tenths_d_reg;
    logic [18:0]        up_d_reg;
    logic [1:0]         oss_d_reg;
    logic               dz_d_reg;

    // stage E: B4, B7
    logic [47:0]        p_b4, p_b7;
    logic [15:0]        kmul;
    logic [16:0]        b4_e;
    logic [31:0]        b7_e;
    logic [P_NUM_W-1:0] num_e_reg;
    logic [P_DEN_W-1:0] den_e_reg;
    bsc_pside_t         side_e_reg;

    always_comb begin
        x2_a      = in_side.qneg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
        b5_a_next = 29'(in_side.x1) + 29'(x2_a);
        b6_a_next = b5_a_next - 29'(C_B6_OFFSET);
    end

    always_comb begin
        sq_b  = 58'(b6_a_reg) * 58'(b6_a_reg);
        p_ac2 = 45'(cal.ac2) * 45'(b6_a_reg);
        p_ac3 = 45'(cal.ac3) * 45'(b6_a_reg);
        tt_b  = 25'((30'(b5_a_reg) + 30'sd8) >>> 4);
        if (tt_b > 25'sd32767) begin
            tenths_b_next = 16'sh7fff;
        end else if (tt_b < -25'sd32768) begin
            tenths_b_next = 16'sh8000;
        end else begin
            tenths_b_next = 16'(tt_b);
        end
    end

    always_comb begin
        p_b2 = 60'(cal.b2) * $signed({17'b0, b6sq_b_reg});
        p_b1 = 60'(cal.b1) * $signed({17'b0, b6sq_b_reg});
    end

    always_comb begin
        x3_d  = 50'(x1b_c_reg) + 50'(x2b_c_reg);
        v_d   = ((55'(cal.ac1) <<< 2) + 55'(x3_d)) <<< oss_c_reg;
        v_d   = v_d + 55'sd2;
        // divide by four, truncating toward zero
        b3_d  = v_d[54] ? ((v_d + 55'sd3) >>> 2) : (v_d >>> 2);
        x3c_d = (45'(x1c_c_reg) + 45'(x2c_c_reg) + 45'sd2) >>> 2;
    end

    always_comb begin
        kmul = 16'(C_B7_SCALE >> oss_d_reg);
        p_b4 = 48'(cal.ac4) * 48'(t_d_reg);
        p_b7 = 48'(32'(up_d_reg) - b3lo_d_reg) * 48'(kmul);
        b4_e = 17'(p_b4[31:0] >> 15);
        b7_e = p_b7[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b5_a_reg  <= b5_a_next;
            b6_a_reg  <= b6_a_next;
            up_a_reg  <= in_side.up;
            oss_a_reg <= in_side.oss;
            dz_a_reg  <= in_side.dz;

            b6sq_b_reg   <= 43'(sq_b >>> 12);
            x2b_b_reg    <= 34'(p_ac2 >>> 11);
            x1c_b_reg    <= 32'(p_ac3 >>> 13);
            tenths_b_reg <= tenths_b_next;
            up_b_reg     <= up_a_reg;
            oss_b_reg    <= oss_a_reg;
            dz_b_reg     <= dz_a_reg;

            x1b_c_reg    <= 49'(p_b2 >>> 11);
            x2c_c_reg    <= 44'(p_b1 >>> 16);
            x2b_c_reg    <= x2b_b_reg;
            x1c_c_reg    <= x1c_b_reg;
            tenths_c_reg <= tenths_b_reg;
            up_c_reg     <= up_b_reg;
            oss_c_reg    <= oss_b_reg;
            dz_c_reg     <= dz_b_reg;

            b3lo_d_reg   <= b3_d[31:0];
            t_d_reg      <= 32'(x3c_d + 45'sd32768);
            tenths_d_reg <= tenths_c_reg;
            up_d_reg     <= up_c_reg;
            oss_d_reg    <= oss_c_reg;
            dz_d_reg     <= dz_c_reg;

            // at or above 2^31 divide first and double after
            num_e_reg         <= b7_e[31] ? b7_e : {b7_e[30:0], 1'b0};
            den_e_reg         <= b4_e;
            side_e_reg.big    <= b7_e[31];
            side_e_reg.err    <= dz_d_reg || (b4_e == '0);
            side_e_reg.tenths <= tenths_d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];
    assign out_num   = num_e_reg;
    assign out_den   = den_e_reg;
    assign out_side  = side_e_reg;

endmodule

[hdl/bsc_post.sv]
// Pressure polynomial correction, whole degrees and result assembly.
module bsc_post (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [bsc_pkg::P_NUM_W-1:0] in_quo,
    input  bsc_pkg::bsc_pside_t      in_side,
    output logic                     out_valid,
    output bsc_pkg::bsc_res_t        out_res
);
    import bsc_pkg::*;

    logic [1:0] vld_reg;

    // stage F
    logic [31:0]        p_f;
    logic [15:0]        tm_f;
    logic [31:0]        p_f_reg;
    logic [47:0]        sq_f_reg;
    logic [44:0]        m2_f_reg;
    logic [31:0]        dm_f_reg;
    logic signed [15:0] tenths_f_reg;
    logic               err_f_reg;

    // stage G
    logic [59:0]        x1p_g;
    logic [12:0]        dmag_g;
    logic [31:0]        p_g_reg;
    logic [43:0]        x1_g_reg;
    logic [29:0]        x2m_g_reg;
    logic signed [12:0] deg_g_reg;
    logic signed [15:0] tenths_g_reg;
    logic               err_g_reg;

    // final
    logic signed [46:0] sacc;
    logic signed [48:0] pres;
    logic [17:0]        pres_sat;

    always_comb begin
        p_f  = in_side.big ? {in_quo[30:0], 1'b0} : in_quo;
        tm_f = in_side.tenths[15] ? 16'(-in_side.tenths) : 16'(in_side.tenths);
    end

    always_comb begin
        x1p_g  = 60'(sq_f_reg) * 60'(C_K_SQ);
        dmag_g = 13'(dm_f_reg >> 19);
    end

    always_comb begin
        // x2 is the negated ceiling of 7357 * p / 2^16
        sacc = $signed({3'b0, x1_g_reg}) - $signed({17'b0, x2m_g_reg}) + 47'(C_K_OFS);
        pres = $signed({17'b0, p_g_reg}) + 49'(sacc >>> 4);
        if (pres < 0) begin
            pres_sat = '0;
        end else if (pres > 49'(C_PRES_MAX)) begin
            pres_sat = 18'(C_PRES_MAX);
        end else begin
            pres_sat = 18'(pres);
        end
        if (err_g_reg) begin
            out_res = '0;
            out_res.err = 1'b1;
        end else begin
            out_res.err      = 1'b0;
            out_res.pressure = pres_sat;
            out_res.degrees  = deg_g_reg;
            out_res.tenths   = tenths_g_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_f_reg      <= p_f;
            sq_f_reg     <= 48'(p_f[31:8]) * 48'(p_f[31:8]);
            m2_f_reg     <= 45'(p_f) * 45'(C_K_LIN);
            dm_f_reg     <= 32'(tm_f) * 32'(C_RECIP10);
            tenths_f_reg <= in_side.tenths;
            err_f_reg    <= in_side.err;

            p_g_reg      <= p_f_reg;
            x1_g_reg     <= 44'(x1p_g >> 16);
            x2m_g_reg    <= 30'((46'(m2_f_reg) + 46'd65535) >> 16);
            deg_g_reg    <= tenths_f_reg[15] ? -$signed(dmag_g) : $signed(dmag_g);
            tenths_g_reg <= tenths_f_reg;
            err_g_reg    <= err_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    assign out_valid = vld_reg[1];

endmodule

[hdl/barometric_sensor_compensation.sv]
// Top level: calibration registers, front stage, dividers and output register.
//
// Compensates raw barometric sensor readings with the standard integer
// algorithm. Calibration words are loaded through the cfg channel
// (cfg_index selects AC1..AC3, AC4..AC6, B1/B2, MC/MD); cfg_ready is always
// high and writes belong only to idle periods.
// Input transactions on s_* carry raw temperature, raw pressure bytes and
// the oversampling mode; each yields exactly one result on m_*.
// Throughput is one transaction per cycle while the pipe is not halted by
// m_tready (see below). The path runs through the front stage, the two
// restoring dividers (DIV_BITS_PER_STAGE quotient bits per stage), the
// coefficient and post stages and the output register.
// All stages move on one shared advance signal. If m_tready is low while a
// result waits, the pipe keeps moving to fill its empty slots and only
// halts once the last stage holds an item, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the
// calibration registers to zero.
module barometric_sensor_compensation #(
    parameter int DIV_BITS_PER_STAGE = bsc_pkg::DIV_BITS_PER_STAGE
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // raw_temperature[15:0], raw_pressure_bytes[39:16]
    input  logic [39:0]                       s_tdata,
    // oversampling[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // temperature_tenths[15:0], temperature_degrees[28:16],
    // pressure_pa[46:29], zero pad[47]
    output logic [47:0]                       m_tdata,
    // divide_error[0]
    output logic                              m_tuser
);
    import bsc_pkg::*;

    bsc_cal_t           cal_reg;
    logic               adv;

    logic [15:0]        ut;
    logic [23:0]        rp;
    logic [1:0]         oss;
    logic signed [33:0] p_x1;
    logic               vld1_reg;
    logic signed [17:0] x1_reg;
    logic [18:0]        up_reg;
    logic [1:0]         oss_reg;

    logic signed [18:0]  d1;
    logic signed [26:0]  tnum;
    logic [T_NUM_W-1:0]  tnum_mag;
    logic [T_DEN_W-1:0]  tden_mag;
    bsc_tside_t          tside_in, tside_out;

    logic               d1_vld;
    logic [T_NUM_W-1:0] d1_quo;
    logic               cf_vld;
    logic [P_NUM_W-1:0] cf_num;
    logic [P_DEN_W-1:0] cf_den;
    bsc_pside_t         pside_in, pside_out;
    logic               d2_vld;
    logic [P_NUM_W-1:0] d2_quo;
    logic               post_vld;
    bsc_res_t           post_res;

    logic               m_tvalid_reg;
    bsc_res_t           res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_valid) begin
            case (bsc_reg_t'(cfg_index))
                REG_AC123: begin
                    cal_reg.ac1 <= cfg_data[47:32];
                    cal_reg.ac2 <= cfg_data[31:16];
                    cal_reg.ac3 <= cfg_data[15:0];
                end
                REG_AC456: begin
                    cal_reg.ac4 <= cfg_data[47:32];
                    cal_reg.ac5 <= cfg_data[31:16];
                    cal_reg.ac6 <= cfg_data[15:0];
                end
                REG_B12: begin
                    cal_reg.b1 <= cfg_data[31:16];
                    cal_reg.b2 <= cfg_data[15:0];
                end
                REG_MCMD: begin
                    cal_reg.mc <= cfg_data[31:16];
                    cal_reg.md <= cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // halt only when the last stage is full and the output cannot drain
    assign adv      = !(post_vld && m_tvalid_reg && !m_tready);
    assign s_tready = adv;

    always_comb begin
        ut   = s_tdata[15:0];
        rp   = s_tdata[39:16];
        oss  = s_tuser;
        p_x1 = 34'($signed({1'b0, ut}) - $signed({1'b0, cal_reg.ac6}))
             * 34'($signed({1'b0, cal_reg.ac5}));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg  <= 18'(p_x1 >>> 15);
            up_reg  <= 19'(rp >> (4'd8 - {2'b0, oss}));
            oss_reg <= oss;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_tvalid;
        end
    end

    // sign-magnitude operands for MC * 2048 / (X1 + MD)
    always_comb begin
        d1       = 19'(x1_reg) + 19'(cal_reg.md);
        tnum     = {cal_reg.mc, 11'b0};
        tnum_mag = tnum[26] ? T_NUM_W'(-tnum) : T_NUM_W'(tnum);
        tden_mag = d1[18] ? T_DEN_W'(-d1) : T_DEN_W'(d1);
        tside_in.x1   = x1_reg;
        tside_in.up   = up_reg;
        tside_in.oss  = oss_reg;
        tside_in.qneg = tnum[26] ^ d1[18];
        tside_in.dz   = (d1 == '0);
    end

    bsc_div #(
        .DW  (T_NUM_W),
        .VW  (T_DEN_W),
        .SW  ($bits(bsc_tside_t)),
        .SPS (DIV_BITS_PER_STAGE)
    ) u_tdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vld1_reg),
        .in_num    (tnum_mag),
        .in_den    (tden_mag),
        .in_side   (tside_in),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_side  (tside_out)
    );

    bsc_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .cal       (cal_reg),
        .in_valid  (d1_vld),
        .in_quo    (d1_quo),
        .in_side   (tside_out),
        .out_valid (cf_vld),
        .out_num   (cf_num),
        .out_den   (cf_den),
        .out_side  (pside_in)
    );

    bsc_div #(
        .DW  (P_NUM_W),
        .VW  (P_DEN_W),
        .SW  ($bits(bsc_pside_t)),
        .SPS (DIV_BITS_PER_STAGE)
    ) u_pdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (cf_vld),
        .in_num    (cf_num),
        .in_den    (cf_den),
        .in_side   (pside_in),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_side  (pside_out)
    );

    bsc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d2_vld),
        .in_quo    (d2_quo),
        .in_side   (pside_out),
        .out_valid (post_vld),
        .out_res   (post_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv && post_vld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && post_vld) begin
            res_reg <= post_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.pressure, res_reg.degrees, res_reg.tenths};
    assign m_tuser  = res_reg.err;

endmodule

[hdl/bsc_check.sv]
// Port-level checks for the compensation block, bound to the top level.
module bsc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an error result carries all-zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 48'd0)
        else $error("error result with nonzero fields");

    // whole degrees never disagree in sign with tenths
    a_deg_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28:16] != 13'd0 |-> m_tdata[28] == m_tdata[15])
        else $error("degree sign mismatch");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input may be refused only while a result is waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without output stall");

endmodule

bind barometric_sensor_compensation bsc_check u_bsc_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
